// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks shared by the RTL, held off while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define GDL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Expression must never be true at a clock edge outside reset.
`define GDL_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition");

`endif

// File: rtl/core/gdl_pkg.sv
// ---------------------------------------------------------------------------
// gdl_pkg
// Shared constants, codes and control structs of the Laplacian block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdl_pkg;

   // Fixed field widths
   localparam int CFG_BITS       = 12;
   localparam int IN_BITS        = 8;
   localparam int OUT_BITS       = 11;
   localparam int CSR_INDEX_BITS = 1;
   localparam int NUM_RESULTS    = 4;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;
   localparam int DEF_PIXEL_BITS = 8;

   // Register value after reset (width and height alike)
   localparam logic [CFG_BITS-1:0] RESET_FRAME_SIZE = 12'd2048;

   // Register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Results one pixel can cause, in delivery order
   typedef enum logic [1:0] {
      RES_UP_LEFT = 2'd0,   // (r-1, c-1)
      RES_UP      = 2'd1,   // (r-1, c) at row end
      RES_LEFT    = 2'd2,   // (r, c-1) on the last row
      RES_HERE    = 2'd3    // (r, c) at the end of the last row
   } res_kind_type;

   // Edge position flags of an accepted pixel, worked out at accept time
   typedef struct packed {
      logic [NUM_RESULTS-1:0] res_en;   // bit per res_kind_type
      logic row_single;                 // frame height is one
      logic col_single;                 // frame width is one
      logic rp_first;                   // row r-1 is the top row
      logic rp_last;                    // row r-1 is the bottom row
      logic rc_first;                   // row r is the top row
      logic rc_last;                    // row r is the bottom row
      logic cp_first;                   // column c-1 is the left column
      logic cp_last;                    // column c-1 is the right column
      logic cc_first;                   // column c is the left column
      logic cc_last;                    // column c is the right column
   } pos_flags_type;

   // Side-band flags of one result word
   typedef struct packed {
      logic frame_done;
      logic burst_last;
   } res_tag_type;

endpackage

// File: rtl/core/gdl_line_ram.sv
// ---------------------------------------------------------------------------
// gdl_line_ram
// Simple dual-port line store: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdl_line_ram #(
   parameter int DEPTH     = gdl_pkg::DEF_MAX_WIDTH,
   parameter int DATA_BITS = 2 * gdl_pkg::DEF_PIXEL_BITS
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DATA_BITS-1:0]         rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DATA_BITS-1:0]         wr_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/gdl_diverge.sv
// ---------------------------------------------------------------------------
// gdl_diverge
// Line-store read/modify/write stage: holds one pixel, its two line-store
// values and the pixel window; hands out its results one per cycle while taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdl_diverge #(
   parameter int MAX_WIDTH  = gdl_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gdl_pkg::DEF_MAX_HEIGHT,
   parameter int PIXEL_BITS = gdl_pkg::DEF_PIXEL_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // pixel entering the stage
   input  logic                              load,
   input  logic [PIXEL_BITS-1:0]             load_pixel,
   input  logic [$clog2(MAX_HEIGHT)-1:0]     load_row,
   input  logic [$clog2(MAX_WIDTH)-1:0]      load_col,
   input  gdl_pkg::pos_flags_type            load_flags,
   // result toward the output register
   output logic                              res_valid,
   input  logic                              res_take,
   output logic signed [gdl_pkg::OUT_BITS-1:0] res_value,
   output logic [gdl_pkg::OUT_BITS-1:0]      res_row,
   output logic [gdl_pkg::OUT_BITS-1:0]      res_col,
   output gdl_pkg::res_tag_type              res_tag,
   // stage frees up at this edge
   output logic                              retire
);

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
   localparam int LINE_BITS = 2 * PIXEL_BITS;
   localparam int TERM_BITS = PIXEL_BITS + 2;
   localparam int SUM_BITS  = PIXEL_BITS + 3;
   localparam int SUM_EXT   = (SUM_BITS > gdl_pkg::OUT_BITS) ? SUM_BITS : gdl_pkg::OUT_BITS;
   localparam int ROW_EXT   = (ROW_BITS > gdl_pkg::OUT_BITS) ? ROW_BITS : gdl_pkg::OUT_BITS;
   localparam int COL_EXT   = (COL_BITS > gdl_pkg::OUT_BITS) ? COL_BITS : gdl_pkg::OUT_BITS;
   localparam int NR        = gdl_pkg::NUM_RESULTS;

   // Second difference with Neumann edges
   function automatic logic signed [TERM_BITS-1:0] edge_term(
      input logic                  is_single,
      input logic                  is_first,
      input logic                  is_last,
      input logic [PIXEL_BITS-1:0] nb,
      input logic [PIXEL_BITS-1:0] nc,
      input logic [PIXEL_BITS-1:0] na
   );
      logic signed [TERM_BITS-1:0] sb;
      logic signed [TERM_BITS-1:0] sc;
      logic signed [TERM_BITS-1:0] sa;
      sb = $signed({2'b00, nb});
      sc = $signed({2'b00, nc});
      sa = $signed({2'b00, na});
      priority if (is_single) edge_term = '0;
      else if (is_first)      edge_term = sa - sc;
      else if (is_last)       edge_term = sb - sc;
      else                    edge_term = sa - (sc <<< 1) + sb;
   endfunction

   // Stage registers
   logic                        s1_valid_ff, s1_valid_in;
   logic [NR-1:0]               pend_ff, pend_in;
   logic [PIXEL_BITS-1:0]       pix_ff;
   logic [ROW_BITS-1:0]         row_ff;
   logic [COL_BITS-1:0]         col_ff;
   gdl_pkg::pos_flags_type      flags_ff;
   logic                        byp_ff;
   logic [LINE_BITS-1:0]        byp_data_ff;

   // Pixel window: current and middle rows at c-1 / c-2, old row at c-1
   logic [PIXEL_BITS-1:0]       cur1_ff, cur2_ff, mid1_ff, mid2_ff, old1_ff;

   // Line store: word holds {row r-2, row r-1} at a column
   logic [LINE_BITS-1:0]        rd_data;
   logic [LINE_BITS-1:0]        wr_data;
   logic [LINE_BITS-1:0]        line_data;
   logic [PIXEL_BITS-1:0]       line_mid;
   logic [PIXEL_BITS-1:0]       line_old;

   gdl_line_ram #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (LINE_BITS)
   ) u_line_ram (
      .clock   (clock),
      .rd_en   (load),
      .rd_addr (load_col),
      .rd_data (rd_data),
      .wr_en   (retire),
      .wr_addr (col_ff),
      .wr_data (wr_data)
   );

   // Forward the retiring write when the next pixel reads the same column
   assign line_data = byp_ff ? byp_data_ff : rd_data;
   assign line_mid  = line_data[PIXEL_BITS-1:0];
   assign line_old  = line_data[LINE_BITS-1:PIXEL_BITS];
   assign wr_data   = {line_mid, pix_ff};

   // Pending results: lowest set bit goes next
   logic [NR-1:0]               pend_next;
   gdl_pkg::res_kind_type       kind;

   assign pend_next = pend_ff & (pend_ff - 1'b1);
   assign res_valid = s1_valid_ff && (pend_ff != '0);
   assign retire    = s1_valid_ff && ((pend_ff == '0) || (res_take && (pend_next == '0)));

   always_comb begin
      priority if (pend_ff[gdl_pkg::RES_UP_LEFT]) kind = gdl_pkg::RES_UP_LEFT;
      else if (pend_ff[gdl_pkg::RES_UP])          kind = gdl_pkg::RES_UP;
      else if (pend_ff[gdl_pkg::RES_LEFT])        kind = gdl_pkg::RES_LEFT;
      else                                        kind = gdl_pkg::RES_HERE;
   end

   // Operand selection for the chosen result
   logic                  v_first, v_last, h_first, h_last;
   logic [PIXEL_BITS-1:0] vb, vc, va, hb, hc, ha;
   logic                  use_prev_row, use_prev_col;

   always_comb begin
      unique case (kind)
         gdl_pkg::RES_UP_LEFT: begin
            v_first = flags_ff.rp_first;  v_last = flags_ff.rp_last;
            vb = old1_ff;  vc = mid1_ff;  va = cur1_ff;
            h_first = flags_ff.cp_first;  h_last = flags_ff.cp_last;
            hb = mid2_ff;  hc = mid1_ff;  ha = line_mid;
            use_prev_row = 1'b1;  use_prev_col = 1'b1;
         end
         gdl_pkg::RES_UP: begin
            v_first = flags_ff.rp_first;  v_last = flags_ff.rp_last;
            vb = line_old;  vc = line_mid;  va = pix_ff;
            h_first = flags_ff.cc_first;  h_last = flags_ff.cc_last;
            hb = mid1_ff;  hc = line_mid;  ha = '0;
            use_prev_row = 1'b1;  use_prev_col = 1'b0;
         end
         gdl_pkg::RES_LEFT: begin
            v_first = flags_ff.rc_first;  v_last = flags_ff.rc_last;
            vb = mid1_ff;  vc = cur1_ff;  va = '0;
            h_first = flags_ff.cp_first;  h_last = flags_ff.cp_last;
            hb = cur2_ff;  hc = cur1_ff;  ha = pix_ff;
            use_prev_row = 1'b0;  use_prev_col = 1'b1;
         end
         gdl_pkg::RES_HERE: begin
            v_first = flags_ff.rc_first;  v_last = flags_ff.rc_last;
            vb = line_mid;  vc = pix_ff;  va = '0;
            h_first = flags_ff.cc_first;  h_last = flags_ff.cc_last;
            hb = cur1_ff;  hc = pix_ff;  ha = '0;
            use_prev_row = 1'b0;  use_prev_col = 1'b0;
         end
      endcase
   end

   // Vertical plus horizontal term
   logic signed [TERM_BITS-1:0] v_term, h_term;
   logic signed [SUM_BITS-1:0]  sum;
   logic signed [SUM_EXT-1:0]   sum_ext;
   logic [ROW_BITS-1:0]         row_sel;
   logic [COL_BITS-1:0]         col_sel;
   logic [ROW_EXT-1:0]          row_ext;
   logic [COL_EXT-1:0]          col_ext;

   assign v_term  = edge_term(flags_ff.row_single, v_first, v_last, vb, vc, va);
   assign h_term  = edge_term(flags_ff.col_single, h_first, h_last, hb, hc, ha);
   assign sum     = SUM_BITS'(v_term) + SUM_BITS'(h_term);
   assign sum_ext = SUM_EXT'(sum);
   assign row_sel = use_prev_row ? (row_ff - 1'b1) : row_ff;
   assign col_sel = use_prev_col ? (col_ff - 1'b1) : col_ff;
   assign row_ext = ROW_EXT'(row_sel);
   assign col_ext = COL_EXT'(col_sel);

   assign res_value          = sum_ext[gdl_pkg::OUT_BITS-1:0];
   assign res_row            = row_ext[gdl_pkg::OUT_BITS-1:0];
   assign res_col            = col_ext[gdl_pkg::OUT_BITS-1:0];
   assign res_tag.frame_done = (kind == gdl_pkg::RES_HERE);
   assign res_tag.burst_last = (pend_next == '0);

   // Stage control
   always_comb begin
      s1_valid_in = s1_valid_ff;
      pend_in     = pend_ff;
      if (load) begin
         s1_valid_in = 1'b1;
         pend_in     = load_flags.res_en;
      end else if (retire) begin
         s1_valid_in = 1'b0;
         pend_in     = '0;
      end else if (res_take) begin
         pend_in     = pend_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pend_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         pend_ff     <= pend_in;
      end
   end

   // Stage payload and forwarding capture
   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff      <= load_pixel;
         row_ff      <= load_row;
         col_ff      <= load_col;
         flags_ff    <= load_flags;
         byp_ff      <= retire && (col_ff == load_col);
         byp_data_ff <= wr_data;
      end
   end

   // Window shifts as each pixel leaves the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         cur1_ff <= '0;
         cur2_ff <= '0;
         mid1_ff <= '0;
         mid2_ff <= '0;
         old1_ff <= '0;
      end else if (retire) begin
         cur2_ff <= cur1_ff;
         cur1_ff <= pix_ff;
         mid2_ff <= mid1_ff;
         mid1_ff <= line_mid;
         old1_ff <= line_old;
      end
   end

endmodule

// File: rtl/core/gradient_divergence_laplacian.sv
// ---------------------------------------------------------------------------
// gradient_divergence_laplacian
// Five-point Laplacian with Neumann edges over a raster pixel stream.
// ---------------------------------------------------------------------------
//  channel   handshake               payload
//  req       req_valid / req_ready   req_pixel_value
//  rsp       rsp_valid / rsp_ready   rsp_divergence_value, rsp_out_row,
//                                    rsp_out_column, rsp_frame_done,
//                                    rsp_burst_last
//  csr       csr_wr_en               csr_index, csr_wdata
//
//  One pixel per cycle while rsp does not stall and each pixel causes at
//  most one result; a pixel that causes more (row ends, last row: up to 4)
//  holds req until the single result port of the line-store stage has
//  handed out all of them. The first result of a pixel goes through the
//  line-store read (at the accepting edge) and then the output register;
//  further results of the same pixel follow one per cycle unless rsp stalls.
//  Reset is synchronous; line stores are not cleared, so no clearing pass.
//  rsp stalls back up through the stage into req_ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gradient_divergence_laplacian #(
   parameter int MAX_WIDTH  = gdl_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gdl_pkg::DEF_MAX_HEIGHT,
   parameter int PIXEL_BITS = gdl_pkg::DEF_PIXEL_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [gdl_pkg::IN_BITS-1:0]           req_pixel_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [gdl_pkg::OUT_BITS-1:0]   rsp_divergence_value,
   output logic [gdl_pkg::OUT_BITS-1:0]          rsp_out_row,
   output logic [gdl_pkg::OUT_BITS-1:0]          rsp_out_column,
   output logic                                  rsp_frame_done,
   output logic                                  rsp_burst_last,
   input  logic                                  csr_wr_en,
   input  logic [gdl_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [gdl_pkg::CFG_BITS-1:0]          csr_wdata
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int ROW_BITS = $clog2(MAX_HEIGHT);
   localparam int CNT_MAX  = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
   localparam int CMP_W    = (CNT_MAX + 1 > gdl_pkg::CFG_BITS) ? CNT_MAX + 1 : gdl_pkg::CFG_BITS;
   localparam int PIX_W    = (PIXEL_BITS > gdl_pkg::IN_BITS) ? PIXEL_BITS : gdl_pkg::IN_BITS;

   // Last index for a size register: zero acts as one, large values clip
   function automatic logic [CMP_W-1:0] last_index(
      input logic [gdl_pkg::CFG_BITS-1:0] size,
      input logic [CMP_W-1:0]             max_size
   );
      logic [CMP_W-1:0] s;
      s = CMP_W'(size);
      priority if (s == '0)     last_index = '0;
      else if (s > max_size)    last_index = max_size - 1'b1;
      else                      last_index = s - 1'b1;
   endfunction

   // Frame size registers, held as last indexes
   logic [CMP_W-1:0]    w_rst_wide, h_rst_wide, w_wr_wide, h_wr_wide;
   logic [COL_BITS-1:0] w_last_ff;
   logic [ROW_BITS-1:0] h_last_ff;

   assign w_rst_wide = last_index(gdl_pkg::RESET_FRAME_SIZE, CMP_W'(MAX_WIDTH));
   assign h_rst_wide = last_index(gdl_pkg::RESET_FRAME_SIZE, CMP_W'(MAX_HEIGHT));
   assign w_wr_wide  = last_index(csr_wdata, CMP_W'(MAX_WIDTH));
   assign h_wr_wide  = last_index(csr_wdata, CMP_W'(MAX_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= w_rst_wide[COL_BITS-1:0];
         h_last_ff <= h_rst_wide[ROW_BITS-1:0];
      end else if (csr_wr_en) begin
         if (csr_index == gdl_pkg::REG_FRAME_WIDTH) begin
            w_last_ff <= w_wr_wide[COL_BITS-1:0];
         end
         if (csr_index == gdl_pkg::REG_FRAME_HEIGHT) begin
            h_last_ff <= h_wr_wide[ROW_BITS-1:0];
         end
      end
   end

   // Raster position of the next input word
   logic                   req_accept;
   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   logic                   row_end, last_row;
   gdl_pkg::pos_flags_type flags;

   assign req_accept = req_valid && req_ready;
   assign row_end    = (col_ff >= w_last_ff);
   assign last_row   = (row_ff >= h_last_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Edge flags and result set of the accepted word
   always_comb begin
      flags.res_en[gdl_pkg::RES_UP_LEFT] = (row_ff != '0) && (col_ff != '0);
      flags.res_en[gdl_pkg::RES_UP]      = (row_ff != '0) && row_end;
      flags.res_en[gdl_pkg::RES_LEFT]    = last_row && (col_ff != '0);
      flags.res_en[gdl_pkg::RES_HERE]    = last_row && row_end;
      flags.row_single = (h_last_ff == '0);
      flags.col_single = (w_last_ff == '0);
      flags.rp_first   = (row_ff == ROW_BITS'(1));
      flags.rp_last    = (row_ff > h_last_ff);
      flags.rc_first   = (row_ff == '0);
      flags.rc_last    = last_row;
      flags.cp_first   = (col_ff == COL_BITS'(1));
      flags.cp_last    = (col_ff > w_last_ff);
      flags.cc_first   = (col_ff == '0);
      flags.cc_last    = row_end;
   end

   // Pixel bits in use
   logic [PIX_W-1:0]      pix_wide;
   logic [PIXEL_BITS-1:0] pix;

   assign pix_wide = PIX_W'(req_pixel_value);
   assign pix      = pix_wide[PIXEL_BITS-1:0];

   // Line-store stage
   logic                                res_valid;
   logic                                res_take;
   logic signed [gdl_pkg::OUT_BITS-1:0] res_value;
   logic [gdl_pkg::OUT_BITS-1:0]        res_row;
   logic [gdl_pkg::OUT_BITS-1:0]        res_col;
   gdl_pkg::res_tag_type                res_tag;
   logic                                retire;
   logic                                s1_busy_ff;

   gdl_diverge #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_diverge (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .load_pixel (pix),
      .load_row   (row_ff),
      .load_col   (col_ff),
      .load_flags (flags),
      .res_valid  (res_valid),
      .res_take   (res_take),
      .res_value  (res_value),
      .res_row    (res_row),
      .res_col    (res_col),
      .res_tag    (res_tag),
      .retire     (retire)
   );

   // Stage occupancy, for the input handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_busy_ff <= 1'b0;
      end else if (req_accept) begin
         s1_busy_ff <= 1'b1;
      end else if (retire) begin
         s1_busy_ff <= 1'b0;
      end
   end

   assign req_ready = !s1_busy_ff || retire;

   // Output register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [gdl_pkg::OUT_BITS-1:0] rsp_value_ff;
   logic [gdl_pkg::OUT_BITS-1:0]        rsp_row_ff;
   logic [gdl_pkg::OUT_BITS-1:0]        rsp_col_ff;
   gdl_pkg::res_tag_type                rsp_tag_ff;

   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_value_ff <= res_value;
         rsp_row_ff   <= res_row;
         rsp_col_ff   <= res_col;
         rsp_tag_ff   <= res_tag;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_divergence_value = rsp_value_ff;
   assign rsp_out_row          = rsp_row_ff;
   assign rsp_out_column       = rsp_col_ff;
   assign rsp_frame_done       = rsp_tag_ff.frame_done;
   assign rsp_burst_last       = rsp_tag_ff.burst_last;

   // Checks
   logic at_origin;

   assign at_origin = (row_ff == '0) && (col_ff == '0);

   // frame end always closes its burst
   `GDL_ASSERT(a_done_is_last, clock, reset, rsp_valid_ff |-> (!rsp_frame_done || rsp_burst_last))
   // a burst still open in the output register keeps the stage offering more
   `GDL_ASSERT(a_burst_open, clock, reset, (rsp_valid_ff && !rsp_burst_last) |-> res_valid)
   // the frame-end result leaves with the raster counters back at the origin
   `GDL_ASSERT_NEVER(a_done_wrap, clock, reset, res_take && res_tag.frame_done && !at_origin)

endmodule
